// ===== design/cir_pkg.sv =====
// Shared types, codes and arithmetic helpers of the contact impulse resolver.
`timescale 1ns / 1ps
package cir_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BODY_IDX_W = 6;
  localparam int unsigned COMP_W     = 3;
  localparam int unsigned SLOP_W     = 31;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned REST_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned BODY_WORDS = 7;
  localparam logic [COMP_W-1:0] INV_WORD = 3'd6;
  localparam logic [COMP_W-1:0] VEL_WORD = 3'd3;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_CONTACT = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_BOTH = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_SKIP = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REST = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd13107;

  localparam int unsigned DIV_DW = 57;
  localparam int unsigned DIV_VW = 33;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r.val  = 32'sh7FFF_FFFF;
      r.clip = 1'b1;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r.val  = -32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = x[WORD_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/cir_if.sv =====
// Valid/ready channel interfaces: contact items, results and register writes.
`timescale 1ns / 1ps
interface cir_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [cir_pkg::BODY_IDX_W-1:0]       first_body;
  logic [cir_pkg::BODY_IDX_W-1:0]       second_body;
  logic                                 first_present;
  logic                                 second_present;
  logic [cir_pkg::COMP_W-1:0]           component;
  logic signed [cir_pkg::WORD_W-1:0]    write_value;
  logic signed [cir_pkg::WORD_W-1:0]    normal_x;
  logic signed [cir_pkg::WORD_W-1:0]    normal_y;
  logic signed [cir_pkg::WORD_W-1:0]    normal_z;
  logic signed [cir_pkg::WORD_W-1:0]    penetration;
  logic                                 contact_active;

  modport source (output valid, action, first_body, second_body, first_present,
                  second_present, component, write_value, normal_x, normal_y,
                  normal_z, penetration, contact_active, input ready);
  modport sink (input valid, action, first_body, second_body, first_present,
                second_present, component, write_value, normal_x, normal_y,
                normal_z, penetration, contact_active, output ready);
endinterface

interface cir_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cir_pkg::WORD_W-1:0] read_value;
  logic [1:0]                        status;
  logic                              saturated;

  modport source (output valid, read_value, status, saturated, input ready);
  modport sink (input valid, read_value, status, saturated, output ready);
endinterface

interface cir_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cir_pkg::CFG_IDX_W-1:0]      index;
  logic [cir_pkg::WORD_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/contact_impulse_resolver.sv =====
// Contact impulse resolver: body table in RAM, sequenced contact resolution.
//
// Channels: in_i carries write, read and contact transactions; out_o returns
// exactly one result transaction per input transaction; cfg_i writes the slop,
// correction gain and restitution registers and is always ready.
// A write, a read, an inactive contact or an unused action is answered without
// the divider; a contact rejected by the penetration or mass check ends at the
// gate. A resolved contact divides once for the position correction and again
// when the impulse follows, on the shared divider of width DW = 57.
// Throughput: one item at a time; in_i.ready is high only while the sequencer
// is idle, which it becomes at the edge that registers the previous result.
// Reset clears the sequencer, the output valid and the registers to their
// defaults; the body table is not cleared and must be written before use.
// A stalled receiver holds the result in the output register; the next input
// transaction is taken meanwhile, and its result waits until the slot frees.
`timescale 1ns / 1ps
module contact_impulse_resolver #(
  parameter int unsigned MAX_BODIES = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cir_in_if.sink      in_i,
  cir_out_if.source   out_o,
  cir_cfg_if.sink     cfg_i
);

  localparam int unsigned DEPTH = MAX_BODIES * cir_pkg::BODY_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned DW    = cir_pkg::DIV_DW;
  localparam int unsigned VW    = cir_pkg::DIV_VW;
  localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_RDW    = 18'b000000000000000010,
    S_INVB   = 18'b000000000000000100,
    S_CHK    = 18'b000000000000001000,
    S_GATE   = 18'b000000000000010000,
    S_DSTART = 18'b000000000000100000,
    S_DWAIT  = 18'b000000000001000000,
    S_NSEL   = 18'b000000000010000000,
    S_NRD    = 18'b000000000100000000,
    S_NM1    = 18'b000000001000000000,
    S_NM2    = 18'b000000010000000000,
    S_NWR    = 18'b000000100000000000,
    S_VSEL   = 18'b000001000000000000,
    S_VRD    = 18'b000010000000000000,
    S_VM     = 18'b000100000000000000,
    S_VACC   = 18'b001000000000000000,
    S_VCHK   = 18'b010000000000000000,
    S_FIN    = 18'b100000000000000000
  } state_e;

  function automatic logic [BW-1:0] body_mod(input logic [cir_pkg::BODY_IDX_W-1:0] b);
    logic [BW-1:0] r;
    r = '0;
    for (int v = 0; v < 64; v++) begin
      if (b == 6'(v)) r = BW'(v % MAX_BODIES);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [BW-1:0] b,
                                            input logic [cir_pkg::COMP_W-1:0] c);
    return AW'(int'(b) * cir_pkg::BODY_WORDS + int'(c));
  endfunction

  state_e state_q, state_d;

  logic [cir_pkg::SLOP_W-1:0] slop_q;
  logic [cir_pkg::GAIN_W-1:0] gain_q;
  logic [cir_pkg::REST_W-1:0] rest_q;

  logic [BW-1:0]               ba_q, bb_q;
  logic                        pa_q, pb_q;
  logic [cir_pkg::COMP_W-1:0]  comp_q;
  logic signed [31:0]          n_q [3];
  logic signed [31:0]          pen_q;
  logic signed [31:0]          ia_q, ib_q, scale_q, t_q;
  logic [VW-1:0]               sum_q;
  logic signed [63:0]          vsum_q, prod_q;
  logic [1:0]                  side_q, axis_q;
  logic                        vel_q, sat_q;
  logic signed [31:0]          rv_q;
  logic [1:0]                  st_q;

  logic                        out_valid_q;
  logic signed [31:0]          out_value_q;
  logic [1:0]                  out_status_q;
  logic                        out_sat_q;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [31:0]                 ram_wdata, ram_rdata;

  logic                        div_start, div_done;
  logic [DW-1:0]               div_quot;

  logic signed [33:0]          mul_a, mul_b;
  logic signed [67:0]          prod_full;
  logic signed [63:0]          prod_fl;
  logic signed [32:0]          pen33, sum33;
  logic signed [32:0]          wr_sum;
  logic signed [33:0]          neg_vn;
  logic [BW-1:0]               body_sel;
  logic signed [31:0]          inv_sel;
  logic                        nudge_en, in_acc, fin_go, sub_sel;
  cir_pkg::sat_t               fl_sat, vn_sat, wr_sat, q_sat;

  cir_ram #(.WIDTH(cir_pkg::WORD_W), .DEPTH(DEPTH)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cir_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[DW-1:0]),
    .divisor_i  (sum_q),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign body_sel = side_q[0] ? bb_q : ba_q;
  assign inv_sel  = side_q[0] ? ib_q : ia_q;
  assign nudge_en = side_q[0] ? (pb_q && ib_q != 0) : (pa_q && ia_q != 0);
  assign sub_sel  = (side_q == 2'd0) ^ vel_q;

  assign pen33   = 33'(pen_q) - 33'($signed({1'b0, slop_q}));
  assign sum33   = 33'(ia_q) + 33'(ib_q);
  assign prod_fl = prod_q >>> FRAC_BITS;
  assign fl_sat  = cir_pkg::sat32(prod_fl);
  assign vn_sat  = cir_pkg::sat32(vsum_q);
  assign neg_vn  = -34'(vn_sat.val);
  assign wr_sum  = sub_sel ? (33'($signed(ram_rdata)) - 33'(fl_sat.val))
                           : (33'($signed(ram_rdata)) + 33'(fl_sat.val));
  assign wr_sat  = cir_pkg::sat32(64'(wr_sum));
  assign q_sat   = cir_pkg::sat32($signed({{(64 - DW){1'b0}}, div_quot}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GATE: begin
        mul_a = 34'($signed({1'b0, gain_q}));
        mul_b = 34'(pen33);
      end
      S_NRD: begin
        mul_a = 34'(n_q[axis_q]);
        mul_b = 34'(scale_q);
      end
      S_NM2: begin
        mul_a = 34'(t_q);
        mul_b = 34'(inv_sel);
      end
      S_VM: begin
        mul_a = 34'($signed(ram_rdata));
        mul_b = 34'(n_q[axis_q]);
      end
      S_VCHK: begin
        mul_a = ONE_Q + 34'($signed({1'b0, rest_q}));
        mul_b = neg_vn;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(body_sel, cir_pkg::COMP_W'(0));
    ram_wdata = wr_sat.val;
    ram_re    = 1'b0;
    ram_raddr = addr_of(body_sel, cir_pkg::COMP_W'(0));
    div_start = 1'b0;
    state_d   = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.action)
            cir_pkg::ACT_WRITE: begin
              ram_we    = in_i.component < cir_pkg::COMP_W'(cir_pkg::BODY_WORDS);
              ram_waddr = addr_of(body_mod(in_i.first_body), in_i.component);
              ram_wdata = in_i.write_value;
              state_d   = S_FIN;
            end
            cir_pkg::ACT_READ: begin
              ram_re    = 1'b1;
              ram_raddr = addr_of(body_mod(in_i.first_body), in_i.component);
              state_d   = S_RDW;
            end
            cir_pkg::ACT_CONTACT: begin
              ram_re    = in_i.contact_active;
              ram_raddr = addr_of(body_mod(in_i.first_body), cir_pkg::INV_WORD);
              state_d   = in_i.contact_active ? S_INVB : S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_RDW:  state_d = S_FIN;
      S_INVB: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(bb_q, cir_pkg::INV_WORD);
        state_d   = S_CHK;
      end
      S_CHK:  state_d = S_GATE;
      S_GATE: state_d = (pen33 > 0 && sum33 > 0) ? S_DSTART : S_FIN;
      S_DSTART: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: if (div_done) state_d = S_NSEL;
      S_NSEL: begin
        if (side_q == 2'd2) begin
          state_d = vel_q ? S_FIN : S_VSEL;
        end else if (nudge_en) begin
          state_d = S_NRD;
        end
      end
      S_NRD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(body_sel, (vel_q ? cir_pkg::VEL_WORD : cir_pkg::COMP_W'(0))
                                      + cir_pkg::COMP_W'(axis_q));
        state_d   = S_NM1;
      end
      S_NM1: state_d = S_NM2;
      S_NM2: state_d = S_NWR;
      S_NWR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(body_sel, (vel_q ? cir_pkg::VEL_WORD : cir_pkg::COMP_W'(0))
                                      + cir_pkg::COMP_W'(axis_q));
        state_d   = (axis_q == 2'd2) ? S_NSEL : S_NRD;
      end
      S_VSEL: begin
        if (side_q == 2'd2) begin
          state_d = S_VCHK;
        end else if (side_q[0] ? pb_q : pa_q) begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(body_sel, cir_pkg::VEL_WORD + cir_pkg::COMP_W'(axis_q));
        state_d   = S_VM;
      end
      S_VM:   state_d = S_VACC;
      S_VACC: state_d = (axis_q == 2'd2) ? S_VSEL : S_VRD;
      S_VCHK: state_d = vn_sat.val < 0 ? S_DSTART : S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      slop_q      <= '0;
      gain_q      <= cir_pkg::GAIN_RESET;
      rest_q      <= '0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          cir_pkg::CFG_SLOP: slop_q <= cfg_i.data[cir_pkg::SLOP_W-1:0];
          cir_pkg::CFG_GAIN: gain_q <= cfg_i.data[cir_pkg::GAIN_W-1:0];
          cir_pkg::CFG_REST: rest_q <= cfg_i.data[cir_pkg::REST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
    if (fin_go) begin
      out_value_q  <= rv_q;
      out_status_q <= st_q;
      out_sat_q    <= sat_q;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ba_q    <= body_mod(in_i.first_body);
          bb_q    <= body_mod(in_i.second_body);
          pa_q    <= in_i.first_present;
          pb_q    <= in_i.second_present;
          comp_q  <= in_i.component;
          n_q[0]  <= in_i.normal_x;
          n_q[1]  <= in_i.normal_y;
          n_q[2]  <= in_i.normal_z;
          pen_q   <= in_i.penetration;
          sat_q   <= 1'b0;
          vel_q   <= 1'b0;
          side_q  <= 2'd0;
          axis_q  <= 2'd0;
          rv_q    <= '0;
          st_q    <= (in_i.action == cir_pkg::ACT_WRITE || in_i.action == cir_pkg::ACT_READ)
                     ? cir_pkg::ST_DONE : cir_pkg::ST_SKIP;
        end
      end
      S_RDW: begin
        if (comp_q < cir_pkg::COMP_W'(cir_pkg::BODY_WORDS)) rv_q <= ram_rdata;
      end
      S_INVB: ia_q <= pa_q ? $signed(ram_rdata) : '0;
      S_CHK:  ib_q <= pb_q ? $signed(ram_rdata) : '0;
      S_GATE: sum_q <= sum33[VW-1:0];
      S_DWAIT: begin
        if (div_done) begin
          scale_q <= q_sat.val;
          sat_q   <= sat_q | q_sat.clip;
          side_q  <= 2'd0;
          axis_q  <= 2'd0;
        end
      end
      S_NSEL: begin
        if (side_q == 2'd2) begin
          if (vel_q) begin
            st_q <= cir_pkg::ST_BOTH;
          end else begin
            side_q <= 2'd0;
            axis_q <= 2'd0;
            vsum_q <= '0;
          end
        end else if (!nudge_en) begin
          side_q <= side_q + 2'd1;
        end
      end
      S_NM1: begin
        t_q   <= fl_sat.val;
        sat_q <= sat_q | fl_sat.clip;
      end
      S_NWR: begin
        sat_q <= sat_q | fl_sat.clip | wr_sat.clip;
        if (axis_q == 2'd2) begin
          axis_q <= 2'd0;
          side_q <= side_q + 2'd1;
        end else begin
          axis_q <= axis_q + 2'd1;
        end
      end
      S_VSEL: begin
        if (side_q != 2'd2 && !(side_q[0] ? pb_q : pa_q)) side_q <= side_q + 2'd1;
      end
      S_VACC: begin
        vsum_q <= side_q[0] ? vsum_q - prod_fl : vsum_q + prod_fl;
        if (axis_q == 2'd2) begin
          axis_q <= 2'd0;
          side_q <= side_q + 2'd1;
        end else begin
          axis_q <= axis_q + 2'd1;
        end
      end
      S_VCHK: begin
        sat_q <= sat_q | vn_sat.clip;
        if (vn_sat.val < 0) begin
          vel_q <= 1'b1;
        end else begin
          st_q <= cir_pkg::ST_POS;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.status     = out_status_q;
  assign out_o.saturated  = out_sat_q;

endmodule

// ===== design/cir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 448
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cir_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cir_div #(
  parameter int unsigned DW = 57,
  parameter int unsigned VW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quot_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dq_q;
  logic [VW:0]   rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q[VW-1:0], dq_q[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      dq_q  <= {dq_q[DW-2:0], fits};
    end
  end

  assign quot_o = dq_q;
  assign done_o = done_q;

endmodule

// ===== design/cir_checker.sv =====
// Port-level checks of the contact impulse resolver, bound to the top level.
`timescale 1ns / 1ps
module cir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_value,
  input logic [1:0]  status,
  input logic        saturated
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the item finished");

  a_value_only_on_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != cir_pkg::ST_DONE |-> read_value == '0)
    else $error("nonzero read value on a contact result");

  a_no_clip_on_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == cir_pkg::ST_DONE || status == cir_pkg::ST_SKIP) |-> !saturated)
    else $error("saturation flagged without arithmetic");

endmodule

bind contact_impulse_resolver cir_checker u_cir_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .read_value (out_o.read_value),
  .status     (out_o.status),
  .saturated  (out_o.saturated)
);

// ===== tb/sv/tb_cir_support.sv =====
// Shared testbench constants of the contact impulse resolver.
`timescale 1ns / 1ps
package tb_cir_support_pkg;
  localparam int unsigned IDLE_MAX = 10;
  localparam logic [1:0]  ACT_NOP  = 2'd3;
endpackage

// ===== tb/sv/tb_contact_impulse_resolver.sv =====
// Testbench of the contact impulse resolver: predicts each result and checks it field by field.
`timescale 1ns / 1ps
module tb_contact_impulse_resolver;

  localparam int unsigned NBODY = 64;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         st;
    logic               sat;
  } outcome_t;

  typedef struct {
    logic [1:0]         action;
    logic [5:0]         ba;
    logic [5:0]         bb;
    logic               pa;
    logic               pb;
    logic [2:0]         comp;
    logic signed [31:0] wval;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] pen;
    logic               active;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cir_in_if  in_ch();
  cir_out_if out_ch();
  cir_cfg_if cfg_ch();

  contact_impulse_resolver dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  logic signed [31:0] bodies [NBODY*7];
  logic [30:0]        slop_q;
  logic [16:0]        gain_q;
  logic [16:0]        rest_q;

  outcome_t expected_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit hold_off = 1'b0;
  bit rx_random = 1'b1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint floor_frac(input longint v);
    return v >>> 16;
  endfunction

  function automatic longint qmul(input longint a, input longint b, inout bit f);
    return clamp32(floor_frac(a * b), f);
  endfunction

  task automatic push_body(input int bi, input int base, input longint n[3],
                           input longint s, input longint inv, input bit add,
                           inout bit f);
    longint d;
    longint r;
    for (int i = 0; i < 3; i++) begin
      d = qmul(qmul(n[i], s, f), inv, f);
      r = add ? longint'(bodies[bi*7+base+i]) + d : longint'(bodies[bi*7+base+i]) - d;
      bodies[bi*7+base+i] = 32'(clamp32(r, f));
    end
  endtask

  task automatic resolve_item(input item_t it, output outcome_t o);
    longint pen, ia, ib, sum, k, vsum, vn, j;
    longint n[3];
    bit f;
    f = 1'b0;
    o = '{value: '0, st: cir_pkg::ST_SKIP, sat: 1'b0};
    if (it.action == cir_pkg::ACT_WRITE) begin
      if (it.comp < 7) bodies[it.ba*7+it.comp] = it.wval;
      o.st = cir_pkg::ST_DONE;
    end else if (it.action == cir_pkg::ACT_READ) begin
      if (it.comp < 7) o.value = bodies[it.ba*7+it.comp];
      o.st = cir_pkg::ST_DONE;
    end else if (it.action == cir_pkg::ACT_CONTACT && it.active) begin
      pen = longint'(it.pen) - longint'(slop_q);
      ia = it.pa ? longint'(bodies[it.ba*7+6]) : 0;
      ib = it.pb ? longint'(bodies[it.bb*7+6]) : 0;
      sum = ia + ib;
      n[0] = it.nx;
      n[1] = it.ny;
      n[2] = it.nz;
      if (pen > 0 && sum > 0) begin
        k = clamp32((longint'(gain_q) * pen) / sum, f);
        if (it.pa && ia != 0) push_body(it.ba, 0, n, k, ia, 1'b0, f);
        if (it.pb && ib != 0) push_body(it.bb, 0, n, k, ib, 1'b1, f);
        vsum = 0;
        for (int i = 0; i < 3; i++) begin
          if (it.pa) vsum += floor_frac(longint'(bodies[it.ba*7+3+i]) * n[i]);
          if (it.pb) vsum -= floor_frac(longint'(bodies[it.bb*7+3+i]) * n[i]);
        end
        vn = clamp32(vsum, f);
        o.st = cir_pkg::ST_POS;
        if (vn < 0) begin
          j = clamp32(((longint'(65536) + longint'(rest_q)) * (-vn)) / sum, f);
          if (it.pa && ia != 0) push_body(it.ba, 3, n, j, ia, 1'b1, f);
          if (it.pb && ib != 0) push_body(it.bb, 3, n, j, ib, 1'b0, f);
          o.st = cir_pkg::ST_BOTH;
        end
      end
    end
    o.sat = f;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_item(input item_t it);
    outcome_t o;
    int idle;
    idle = $urandom_range(0, tb_cir_support_pkg::IDLE_MAX);
    if ($urandom_range(0, 3) == 0) idle = 0;
    repeat (idle + 1) @(posedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.action         <= it.action;
    in_ch.first_body     <= it.ba;
    in_ch.second_body    <= it.bb;
    in_ch.first_present  <= it.pa;
    in_ch.second_present <= it.pb;
    in_ch.component      <= it.comp;
    in_ch.write_value    <= it.wval;
    in_ch.normal_x       <= it.nx;
    in_ch.normal_y       <= it.ny;
    in_ch.normal_z       <= it.nz;
    in_ch.penetration    <= it.pen;
    in_ch.contact_active <= it.active;
    do @(posedge clk_i); while (!in_ch.ready);
    resolve_item(it, o);
    expected_q.push_back(o);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      cir_pkg::CFG_SLOP: slop_q = val[30:0];
      cir_pkg::CFG_GAIN: gain_q = val[16:0];
      cir_pkg::CFG_REST: rest_q = val[16:0];
      default: ;
    endcase
  endtask

  function automatic item_t blank_item();
    item_t it;
    it = '{action: cir_pkg::ACT_WRITE, ba: '0, bb: '0, pa: 1'b0, pb: 1'b0, comp: '0,
           wval: '0, nx: '0, ny: '0, nz: '0, pen: '0, active: 1'b0};
    return it;
  endfunction

  function automatic logic signed [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 131072)) - 65536;
      default: return $signed($urandom_range(0, 2048)) - 1024;
    endcase
  endfunction

  task automatic put_word(input int b, input int c, input logic signed [31:0] v);
    item_t it;
    it = blank_item();
    it.action = cir_pkg::ACT_WRITE;
    it.ba = 6'(b);
    it.comp = 3'(c);
    it.wval = v;
    send_item(it);
  endtask

  task automatic load_bodies(input int first, input int count);
    for (int b = first; b < first + count; b++)
      for (int c = 0; c < 7; c++)
        put_word(b, c, (c == 6) ? rand_word(1 + $urandom_range(0, 1)) & 32'h7fff_ffff
                                 : rand_word($urandom_range(0, 2)));
  endtask

  task automatic send_random(input int bodies_used);
    item_t it;
    int sel;
    it = blank_item();
    sel = $urandom_range(0, 99);
    it.ba = 6'($urandom_range(0, bodies_used - 1));
    it.bb = 6'($urandom_range(0, bodies_used - 1));
    it.comp = 3'($urandom_range(0, 7));
    if (sel < 55) begin
      it.action = cir_pkg::ACT_CONTACT;
      it.pa = ($urandom_range(0, 7) != 0);
      it.pb = ($urandom_range(0, 7) != 0);
      it.active = ($urandom_range(0, 9) != 0);
      it.nx = rand_word($urandom_range(0, 9) == 0 ? 0 : 1);
      it.ny = rand_word($urandom_range(0, 9) == 0 ? 0 : 1);
      it.nz = rand_word($urandom_range(0, 9) == 0 ? 0 : 1);
      it.pen = rand_word($urandom_range(0, 9) == 0 ? 0 : 1);
    end else if (sel < 75) begin
      it.action = cir_pkg::ACT_WRITE;
      it.wval = rand_word($urandom_range(0, 2));
      if (it.comp == 6 && $urandom_range(0, 3) != 0) it.wval = rand_word(2) & 32'h0000_ffff;
    end else if (sel < 97) begin
      it.action = cir_pkg::ACT_READ;
    end else begin
      it.action = tb_cir_support_pkg::ACT_NOP;
      it.wval = $urandom;
    end
    send_item(it);
  endtask

  task automatic test_extremes();
    item_t it;
    load_bodies(0, 4);
    put_word(63, 6, 32'sh7fff_ffff);
    for (int c = 0; c < 6; c++) put_word(63, c, (c % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff);
    put_word(0, 7, 32'h1234);
    put_word(2, 6, 0);
    put_word(3, 6, -32'sd5);
    it = blank_item();
    it.action = cir_pkg::ACT_READ;
    it.ba = 6'd63;
    for (int c = 0; c < 8; c++) begin
      it.comp = 3'(c);
      send_item(it);
    end
    it = blank_item();
    it.action = tb_cir_support_pkg::ACT_NOP;
    send_item(it);
    it = blank_item();
    it.action = cir_pkg::ACT_CONTACT;
    it.active = 1'b1;
    it.pa = 1'b1;
    it.pb = 1'b1;
    it.ba = 6'd63;
    it.bb = 6'd63;
    it.nx = 32'sh7fff_ffff;
    it.ny = 32'sh8000_0000;
    it.nz = 32'sh0001_0000;
    it.pen = 32'sh7fff_ffff;
    send_item(it);
    it.ba = 6'd2;
    it.bb = 6'd0;
    send_item(it);
    it.ba = 6'd3;
    it.bb = 6'd1;
    it.pen = 32'sh8000_0000;
    send_item(it);
    it.pen = 32'sh0000_8000;
    it.active = 1'b0;
    send_item(it);
    drain();
  endtask

  task automatic test_settings();
    logic [31:0] slops[3] = '{32'h0, 32'h0000_4000, 32'hffff_ffff};
    logic [31:0] gains[3] = '{32'h0, 32'h0001_0000, 32'h0000_8000};
    logic [31:0] rests[3] = '{32'h0001_0000, 32'h0, 32'h0000_4000};
    for (int p = 0; p < 3; p++) begin
      write_reg(cir_pkg::CFG_SLOP, slops[p]);
      write_reg(cir_pkg::CFG_GAIN, gains[p]);
      write_reg(cir_pkg::CFG_REST, rests[p]);
      for (int i = 0; i < 60; i++) send_random(4);
      drain();
    end
    write_reg(cir_pkg::CFG_SLOP, 32'h7fff_ffff);
    for (int i = 0; i < 10; i++) send_random(4);
    drain();
    write_reg(cir_pkg::CFG_SLOP, 32'h0000_0100);
    write_reg(cir_pkg::CFG_GAIN, 32'h0000_3333);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_random(4);
    join
    drain();
  endtask

  task automatic test_random();
    load_bodies(4, 8);
    for (int i = 0; i < 400; i++) begin
      if (i % 100 == 50) rx_random = ~rx_random;
      send_random(12);
      if (i % 150 == 149) drain();
    end
    rx_random = 1'b1;
    drain();
  endtask

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", out_ch.status, -1);
      end else begin
        automatic outcome_t w = expected_q.pop_front();
        if (out_ch.read_value !== w.value) report_mismatch("read_value", out_ch.read_value, w.value);
        if (out_ch.status !== w.st) report_mismatch("status", out_ch.status, w.st);
        if (out_ch.saturated !== w.sat) report_mismatch("saturated", out_ch.saturated, w.sat);
      end
    end
  end

  int rx_wait = 0;
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      rx_wait <= rx_random ? $urandom_range(0, tb_cir_support_pkg::IDLE_MAX) : 0;
      out_ch.ready <= !rx_random;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.first_body = '0;
    in_ch.second_body = '0;
    in_ch.first_present = 1'b0;
    in_ch.second_present = 1'b0;
    in_ch.component = '0;
    in_ch.write_value = '0;
    in_ch.normal_x = '0;
    in_ch.normal_y = '0;
    in_ch.normal_z = '0;
    in_ch.penetration = '0;
    in_ch.contact_active = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    slop_q = '0;
    gain_q = cir_pkg::GAIN_RESET;
    rest_q = '0;
    foreach (bodies[i]) bodies[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_settings();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
